// File: rtl/sieu_pkg.sv
`default_nettype none

package sieu_pkg;

	localparam int WORD_W   = 32;
	localparam int KIND_W   = 4;
	localparam int SP_OUT_W = 12;

	// Opcodes; codes above OP_ADD have no meaning and execute as invalid
	typedef enum logic [KIND_W-1:0] {
		OP_INVALID = 4'd0,
		OP_STI     = 4'd1,
		OP_NOP     = 4'd2,
		OP_JMPABS  = 4'd3,
		OP_PUSH    = 4'd4,
		OP_POP     = 4'd5,
		OP_MOV     = 4'd6,
		OP_XOR     = 4'd7,
		OP_ADD     = 4'd8
	} op_t;

	typedef struct packed {
		logic carry;
		logic zero;
	} flags_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] operand_a;
		logic [WORD_W-1:0] operand_b;
	} instr_t;

	typedef struct packed {
		logic                reg_written;
		logic [WORD_W-1:0]   written_value;
		logic [WORD_W-1:0]   instr_pointer;
		logic [SP_OUT_W-1:0] stack_pointer;
		logic                zero_flag;
		logic                carry_flag;
		logic                invalid_op;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/sieu_stream_if.sv
`default_nettype none

interface sieu_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/small_isa_execute_unit_core.sv
// An accepted instruction enters the execute stage; its result is registered at commit.
// Throughput: one instruction per cycle unless stalled; register file and stack memory
// reads issue at acceptance, write-back happens at commit, with same-cycle forwarding.
// Reset (arst_n low, asynchronous) zeroes the registers, pointers and flags and empties
// the pipeline; stack memory contents are undefined until written.
// NUM_REGS and MEM_BYTES must be powers of two (not enforced); SP stays word aligned.
`default_nettype none

module small_isa_execute_unit_core
	import sieu_pkg::*;
#(
	parameter int NUM_REGS  = 16,
	parameter int MEM_BYTES = 4096
) (
	input wire logic      clk,
	input wire logic      arst_n,
	sieu_stream_if.sink   instr,
	sieu_stream_if.source result
);

	localparam int RI_W      = $clog2(NUM_REGS);
	localparam int SP_W      = $clog2(MEM_BYTES);
	localparam int WA_W      = SP_W - 2;
	localparam int MEM_WORDS = MEM_BYTES / 4;

	// Architectural pointers and flags
	logic [WORD_W-1:0] ip_q, ip_nxt;
	logic [SP_W-1:0]   sp_q, sp_nxt;
	flags_t            flags_q;

	// Issue stage
	logic            acc;
	op_t             op_in;
	logic [RI_W-1:0] ra, rb, dst_idx;

	// Execute stage
	logic              valid_s1;
	op_t               op_s1;
	logic [WORD_W-1:0] imm_s1, ip_s1;
	logic [SP_W-1:0]   sp_s1;
	logic [RI_W-1:0]   dst_s1;
	logic              commit;

	logic [WORD_W-1:0] rf_a, rf_b, mem_rd;
	logic [WORD_W:0]   sum;
	logic [WORD_W-1:0] wr_val;
	logic              reg_wr, mem_wr, flags_upd, inv;
	flags_t            flags_new, flags_out;
	logic              rf_wr_en, mem_wr_en;

	// Output register
	logic    out_valid_q;
	result_t out_q;

	// Handshake: take a new instruction whenever the execute stage frees up
	assign commit      = valid_s1 && (!out_valid_q || result.ready);
	assign instr.ready = !valid_s1 || commit;
	assign acc         = instr.valid && instr.ready;

	assign op_in = op_t'(instr.data.kind);
	assign ra    = instr.data.operand_a[RI_W-1:0];
	assign rb    = instr.data.operand_b[RI_W-1:0];

	// Decode pointer updates and destination at issue
	always_comb begin
		sp_nxt  = sp_q;
		ip_nxt  = ip_q;
		dst_idx = ra;
		unique case (op_in)
			OP_STI:    dst_idx = rb;
			OP_JMPABS: ip_nxt  = instr.data.operand_a;
			OP_PUSH:   sp_nxt  = sp_q - SP_W'(4);
			OP_POP:    sp_nxt  = sp_q + SP_W'(4);
			default:   ;
		endcase
	end

	sieu_regfile #(
		.NUM_REGS (NUM_REGS),
		.RI_W     (RI_W)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (acc),
		.rd_addr_a (ra),
		.rd_addr_b (rb),
		.rd_data_a (rf_a),
		.rd_data_b (rf_b),
		.wr_en     (rf_wr_en),
		.wr_addr   (dst_s1),
		.wr_data   (wr_val)
	);

	sieu_stack_mem #(
		.WORDS (MEM_WORDS),
		.WA_W  (WA_W)
	) u_stack_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (sp_q[SP_W-1:2]),
		.rd_data (mem_rd),
		.wr_en   (mem_wr_en),
		.wr_addr (sp_s1[SP_W-1:2]),
		.wr_data (rf_a)
	);

	// Execute: select write-back value and new flags
	assign sum = {1'b0, rf_a} + {1'b0, rf_b};

	always_comb begin
		wr_val    = '0;
		reg_wr    = 1'b0;
		mem_wr    = 1'b0;
		flags_upd = 1'b0;
		flags_new = flags_q;
		inv       = 1'b0;
		unique case (op_s1)
			OP_STI: begin
				reg_wr = 1'b1;
				wr_val = imm_s1;
			end
			OP_PUSH: mem_wr = 1'b1;
			OP_POP: begin
				reg_wr = 1'b1;
				wr_val = mem_rd;
			end
			OP_MOV: begin
				reg_wr = 1'b1;
				wr_val = rf_b;
			end
			OP_XOR: begin
				reg_wr          = 1'b1;
				wr_val          = rf_a ^ rf_b;
				flags_upd       = 1'b1;
				flags_new.carry = 1'b0;
				flags_new.zero  = ((rf_a ^ rf_b) == '0);
			end
			OP_ADD: begin
				reg_wr          = 1'b1;
				wr_val          = sum[WORD_W-1:0];
				flags_upd       = 1'b1;
				flags_new.carry = sum[WORD_W];
				flags_new.zero  = (sum[WORD_W-1:0] == '0);
			end
			OP_NOP, OP_JMPABS: ;
			default: inv = 1'b1;
		endcase
	end

	assign rf_wr_en  = commit && reg_wr;
	assign mem_wr_en = commit && mem_wr;
	assign flags_out = flags_upd ? flags_new : flags_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			ip_q        <= '0;
			sp_q        <= '0;
			flags_q     <= '0;
		end else begin
			if (acc) begin
				ip_q <= ip_nxt;
				sp_q <= sp_nxt;
			end
			if (commit) begin
				flags_q <= flags_out;
			end
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Advance payload through execute and output registers
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1  <= op_in;
			imm_s1 <= instr.data.operand_a;
			dst_s1 <= dst_idx;
			ip_s1  <= ip_nxt;
			sp_s1  <= sp_nxt;
		end
		if (commit) begin
			out_q.reg_written   <= reg_wr;
			out_q.written_value <= wr_val;
			out_q.instr_pointer <= ip_s1;
			out_q.stack_pointer <= SP_OUT_W'(sp_s1);
			out_q.zero_flag     <= flags_out.zero;
			out_q.carry_flag    <= flags_out.carry;
			out_q.invalid_op    <= inv;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// The stack pointer only moves by whole words
	a_sp_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q[1:0] == 2'b00)
		else $error("stack pointer lost word alignment");

	// A commit never writes both the register file and the stack memory
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(rf_wr_en && mem_wr_en))
		else $error("register and stack write in the same cycle");

	// Input back-pressure only when both stages are full and the output stalls
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!instr.ready |-> (valid_s1 && out_valid_q && !result.ready))
		else $error("input stalled without a full pipeline");

	// An accepted instruction occupies the execute stage next cycle
	a_issue: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> valid_s1)
		else $error("accepted instruction lost before execute");

	// A committed instruction presents a result next cycle
	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("committed instruction produced no result");

endmodule

`default_nettype wire

// File: rtl/sieu_regfile.sv
`default_nettype none

module sieu_regfile
	import sieu_pkg::*;
#(
	parameter int NUM_REGS = 16,
	parameter int RI_W     = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [RI_W-1:0]   rd_addr_a,
	input  wire logic [RI_W-1:0]   rd_addr_b,
	output logic      [WORD_W-1:0] rd_data_a,
	output logic      [WORD_W-1:0] rd_data_b,
	input  wire logic              wr_en,
	input  wire logic [RI_W-1:0]   wr_addr,
	input  wire logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0]   mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [WORD_W-1:0]   ram_a_q, ram_b_q, byp_data_q;
	logic                rvld_a_q, rvld_b_q, byp_a_q, byp_b_q;

	// Write port and synchronous read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ram_a_q    <= mem[rd_addr_a];
			ram_b_q    <= mem[rd_addr_b];
			byp_data_q <= wr_data;
		end
	end

	// Track written entries and flag reads that collide with a same-cycle write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rvld_a_q <= 1'b0;
			rvld_b_q <= 1'b0;
			byp_a_q  <= 1'b0;
			byp_b_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_a_q <= vld_q[rd_addr_a];
				rvld_b_q <= vld_q[rd_addr_b];
				byp_a_q  <= wr_en && (wr_addr == rd_addr_a);
				byp_b_q  <= wr_en && (wr_addr == rd_addr_b);
			end
		end
	end

	// Forward the colliding write, else zero for never-written entries
	assign rd_data_a = byp_a_q ? byp_data_q : (rvld_a_q ? ram_a_q : '0);
	assign rd_data_b = byp_b_q ? byp_data_q : (rvld_b_q ? ram_b_q : '0);

endmodule

`default_nettype wire

// File: rtl/sieu_stack_mem.sv
`default_nettype none

module sieu_stack_mem
	import sieu_pkg::*;
#(
	parameter int WORDS = 1024,
	parameter int WA_W  = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [WA_W-1:0]   rd_addr,
	output logic      [WORD_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [WA_W-1:0]   wr_addr,
	input  wire logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] ram_q, byp_data_q;
	logic              byp_q;

	// Word-wide write port and synchronous read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ram_q      <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// Flag a read that collides with a same-cycle write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : ram_q;

endmodule

`default_nettype wire
